>>> rtl/core/vfl_pkg.sv
// shared types and constants for the vector field line fir core
// used by vfl_lane, vfl_merge and vector_field_line_fir_core; no dependencies
`default_nettype none

package vfl_pkg;

  // sample and tap formats (Q7.8 samples, Q0.15 taps)
  localparam int SAMPLE_BITS = 16;
  localparam int TAP_BITS    = 16;
  localparam int FRAC_SHIFT  = 15;
  localparam int PROD_BITS   = SAMPLE_BITS + TAP_BITS;

  // one lane per vector component
  localparam int LANES = 3;

  // default kernel size and configuration layout
  localparam int DEF_MAX_HALF_WIDTH = 3;
  localparam int HW_BITS            = 2;
  localparam int CFG_DATA_BITS      = 16;
  localparam int REG_HALF_WIDTH     = 0;
  localparam int REG_TAP_BASE       = 1;

  // reset kernel is a unit impulse
  localparam logic signed [TAP_BITS-1:0] TAP0_RESET = 16'sh7FFF;

  // output saturation limits
  localparam int SAT_HI = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int SAT_LO = -(1 << (SAMPLE_BITS - 1));

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [TAP_BITS-1:0]    tap_t;
  typedef sample_t [LANES-1:0]           vec_t;

  // input beat
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] in_x;
    logic signed [SAMPLE_BITS-1:0] in_y;
    logic signed [SAMPLE_BITS-1:0] in_z;
    logic                          line_last;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_x;
    logic signed [SAMPLE_BITS-1:0] out_y;
    logic signed [SAMPLE_BITS-1:0] out_z;
    logic                          run_last;
    logic                          line_done;
  } out_beat_t;

  // flags that travel down the pipeline with each result
  typedef struct packed {
    logic run_last;
    logic line_done;
  } ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/vfl_lane.sv
// one component lane: tap products, then their sum
// depends on vfl_pkg
`default_nettype none

module vfl_lane #(
  parameter int TAP_COUNT = 2 * vfl_pkg::DEF_MAX_HALF_WIDTH + 1,
  parameter int ACC_BITS  = vfl_pkg::PROD_BITS + $clog2(2 * vfl_pkg::DEF_MAX_HALF_WIDTH + 1)
) (
  input  logic                       clk,
  input  logic                       mul_en,
  input  logic                       sum_en,
  input  vfl_pkg::sample_t           samp [TAP_COUNT],
  input  vfl_pkg::tap_t              taps [TAP_COUNT],
  output logic signed [ACC_BITS-1:0] acc
);

  logic signed [vfl_pkg::PROD_BITS-1:0] prod [TAP_COUNT];
  logic signed [ACC_BITS-1:0]           sum;

  // product stage, one multiplier per tap
  always_ff @(posedge clk) begin
    if (mul_en) begin
      for (int j = 0; j < TAP_COUNT; j++) begin
        prod[j] <= samp[j] * taps[j];
      end
    end
  end

  // sum of all products
  always_comb begin
    sum = '0;
    for (int j = 0; j < TAP_COUNT; j++) begin
      sum = sum + ACC_BITS'(prod[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (sum_en) begin
      acc <= sum;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/vfl_merge.sv
// merge stage: rounds and saturates the lane sums into one output beat
// depends on vfl_pkg
`default_nettype none

module vfl_merge #(
  parameter int ACC_BITS = vfl_pkg::PROD_BITS + $clog2(2 * vfl_pkg::DEF_MAX_HALF_WIDTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic signed [ACC_BITS-1:0] acc [vfl_pkg::LANES],
  input  vfl_pkg::ctl_t              ctl,
  output logic                       ready,
  output logic                       result_valid,
  input  logic                       result_stall,
  output vfl_pkg::out_beat_t         result
);

  localparam int RB = ACC_BITS + 1 - vfl_pkg::FRAC_SHIFT;

  logic signed [ACC_BITS:0] biased [vfl_pkg::LANES];
  logic signed [RB-1:0]     rnd    [vfl_pkg::LANES];
  vfl_pkg::sample_t         sat    [vfl_pkg::LANES];

  // round half up, then clamp to the sample range
  always_comb begin
    for (int l = 0; l < vfl_pkg::LANES; l++) begin
      biased[l] = (ACC_BITS + 1)'(acc[l])
                + (ACC_BITS + 1)'(1 << (vfl_pkg::FRAC_SHIFT - 1));
      rnd[l]    = RB'(biased[l] >>> vfl_pkg::FRAC_SHIFT);
      if (rnd[l] > $signed(RB'(vfl_pkg::SAT_HI))) begin
        sat[l] = vfl_pkg::sample_t'(vfl_pkg::SAT_HI);
      end else if (rnd[l] < $signed(RB'(vfl_pkg::SAT_LO))) begin
        sat[l] = vfl_pkg::sample_t'(vfl_pkg::SAT_LO);
      end else begin
        sat[l] = vfl_pkg::SAMPLE_BITS'(rnd[l]);
      end
    end
  end

  assign ready = !result_valid || !result_stall;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready) begin
      result_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      result.out_x     <= sat[0];
      result.out_y     <= sat[1];
      result.out_z     <= sat[2];
      result.run_last  <= ctl.run_last;
      result.line_done <= ctl.line_done;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/vector_field_line_fir_core.sv
// Line FIR over a three-component vector field: 2*hw+1 taps, where hw is the
// half-width register, with zero padding outside the line. Voxels are taken one
// per cycle while voxel_stall is low. A voxel that ends a line emits up to hw+1
// results, one per cycle from the issue stage while the pipeline moves, and the
// input stalls until its last result issues. A voxel's first result passes operand
// select, products, sum, round and output register; the rest of a flush one per cycle.
// There is no clearing pass after reset. depends on vfl_pkg, vfl_lane, vfl_merge
`default_nettype none

module vector_field_line_fir_core #(
  parameter int MAX_HALF_WIDTH = vfl_pkg::DEF_MAX_HALF_WIDTH
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_we,
  input  logic [$clog2(2*MAX_HALF_WIDTH+2)-1:0]    cfg_index,
  input  logic [vfl_pkg::CFG_DATA_BITS-1:0]        cfg_data,
  input  logic                                     voxel_valid,
  output logic                                     voxel_stall,
  input  vfl_pkg::in_beat_t                        voxel,
  output logic                                     result_valid,
  input  logic                                     result_stall,
  output vfl_pkg::out_beat_t                       result
);

  localparam int TAP_COUNT = 2 * MAX_HALF_WIDTH + 1;
  localparam int IDXW      = $clog2(TAP_COUNT);
  localparam int FILLW     = $clog2(TAP_COUNT + 1);
  localparam int CFGW      = $clog2(TAP_COUNT + 1);
  localparam int MW        = $clog2(MAX_HALF_WIDTH + 1);
  localparam int ACC_BITS  = vfl_pkg::PROD_BITS + $clog2(TAP_COUNT);

  // configuration registers
  logic [vfl_pkg::HW_BITS-1:0] hw;
  vfl_pkg::tap_t               taps [TAP_COUNT];

  // line state
  vfl_pkg::vec_t    win       [TAP_COUNT];
  vfl_pkg::vec_t    win_shift [TAP_COUNT];
  logic [FILLW-1:0] line_fill;

  // issue job
  logic          job_valid;
  vfl_pkg::vec_t job_win [TAP_COUNT];
  logic [MW-1:0] job_h;
  logic [MW-1:0] job_m;
  logic [MW-1:0] job_mend;
  logic          job_last;

  logic          accept;
  logic          issue_fire;
  logic          issue_end;
  logic [MW-1:0] h_eff;
  logic [MW-1:0] m_start;
  logic [MW-1:0] m_end;
  logic          has_res;
  logic [IDXW-1:0] d_sel;
  vfl_pkg::vec_t sel [TAP_COUNT];
  vfl_pkg::ctl_t issue_ctl;

  // pipeline stages
  logic          s1_valid, s2_valid, s3_valid;
  logic          s1_ready, s2_ready, s3_ready;
  vfl_pkg::ctl_t s1_ctl, s2_ctl, s3_ctl;
  vfl_pkg::vec_t s1_samp [TAP_COUNT];
  logic          merge_ready;

  vfl_pkg::sample_t          lane_samp [vfl_pkg::LANES][TAP_COUNT];
  logic signed [ACC_BITS-1:0] lane_acc [vfl_pkg::LANES];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hw <= '0;
      for (int j = 0; j < TAP_COUNT; j++) begin
        taps[j] <= (j == 0) ? vfl_pkg::TAP0_RESET : '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == CFGW'(vfl_pkg::REG_HALF_WIDTH)) begin
        hw <= cfg_data[vfl_pkg::HW_BITS-1:0];
      end else if (cfg_index <= CFGW'(TAP_COUNT)) begin
        taps[IDXW'(cfg_index - CFGW'(vfl_pkg::REG_TAP_BASE))] <=
          vfl_pkg::tap_t'(cfg_data[vfl_pkg::TAP_BITS-1:0]);
      end
    end
  end

  // effective half width and the range of output offsets this beat produces
  assign h_eff   = (int'(hw) > MAX_HALF_WIDTH) ? MW'(MAX_HALF_WIDTH) : MW'(hw);
  assign has_res = (FILLW'(h_eff) <= line_fill) || voxel.line_last;
  assign m_start = (FILLW'(h_eff) <= line_fill) ? '0 : MW'(FILLW'(h_eff) - line_fill);
  assign m_end   = voxel.line_last ? h_eff : '0;

  // window after the new voxel shifts in, newest first
  always_comb begin
    win_shift[0] = {voxel.in_z, voxel.in_y, voxel.in_x};
    for (int i = 1; i < TAP_COUNT; i++) begin
      win_shift[i] = win[i-1];
    end
  end

  // handshake: hold the input while the job still has more than this cycle's result
  assign issue_fire  = job_valid && s1_ready;
  assign issue_end   = job_m == job_mend;
  assign voxel_stall = job_valid && !(issue_fire && issue_end);
  assign accept      = voxel_valid && !voxel_stall;

  // sample window and fill count, cleared at line end
  always_ff @(posedge clk) begin
    if (rst) begin
      line_fill <= '0;
      for (int i = 0; i < TAP_COUNT; i++) begin
        win[i] <= '0;
      end
    end else if (accept) begin
      if (voxel.line_last) begin
        line_fill <= '0;
        for (int i = 0; i < TAP_COUNT; i++) begin
          win[i] <= '0;
        end
      end else begin
        if (line_fill != FILLW'(TAP_COUNT)) begin
          line_fill <= line_fill + 1'b1;
        end
        win <= win_shift;
      end
    end
  end

  // job control
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (accept) begin
      job_valid <= has_res;
    end else if (issue_fire && issue_end) begin
      job_valid <= 1'b0;
    end
  end

  // job payload: window snapshot and offset counter
  always_ff @(posedge clk) begin
    if (accept) begin
      job_win  <= win_shift;
      job_h    <= h_eff;
      job_m    <= m_start;
      job_mend <= m_end;
      job_last <= voxel.line_last;
    end else if (issue_fire && !issue_end) begin
      job_m <= job_m + 1'b1;
    end
  end

  // operand select: tap j meets window entry 2h-m-j, zero past the line start
  assign d_sel = IDXW'({job_h, 1'b0}) - IDXW'(job_m);

  always_comb begin
    for (int j = 0; j < TAP_COUNT; j++) begin
      if (IDXW'(j) <= d_sel) begin
        sel[j] = job_win[d_sel - IDXW'(j)];
      end else begin
        sel[j] = '0;
      end
    end
    issue_ctl.run_last  = issue_end;
    issue_ctl.line_done = issue_end && job_last;
  end

  // ready chain through the pipeline
  assign s3_ready = !s3_valid || merge_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= issue_fire;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_samp <= sel;
      s1_ctl  <= issue_ctl;
    end
    if (s2_ready) begin
      s2_ctl <= s1_ctl;
    end
    if (s3_ready) begin
      s3_ctl <= s2_ctl;
    end
  end

  // one lane per component
  for (genvar l = 0; l < vfl_pkg::LANES; l++) begin : g_lane
    for (genvar j = 0; j < TAP_COUNT; j++) begin : g_tap
      assign lane_samp[l][j] = s1_samp[j][l];
    end

    vfl_lane #(
      .TAP_COUNT (TAP_COUNT),
      .ACC_BITS  (ACC_BITS)
    ) u_lane (
      .clk    (clk),
      .mul_en (s2_ready),
      .sum_en (s3_ready),
      .samp   (lane_samp[l]),
      .taps   (taps),
      .acc    (lane_acc[l])
    );
  end

  vfl_merge #(
    .ACC_BITS (ACC_BITS)
  ) u_merge (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s3_valid),
    .acc          (lane_acc),
    .ctl          (s3_ctl),
    .ready        (merge_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // line end is always the final beat of its voxel
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!result.line_done || result.run_last))
    else $error("line_done without run_last");

  // a line-ending voxel restarts the fill count
  a_fill_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && voxel.line_last) |=> (line_fill == '0))
    else $error("fill count not cleared at line end");

  // no new voxel while a flush has more than one beat left
  a_flush_hold: assert property (@(posedge clk) disable iff (rst)
    (job_valid && !issue_end) |-> voxel_stall)
    else $error("voxel taken during flush");

  // fill count saturates at the window depth
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    line_fill <= FILLW'(TAP_COUNT))
    else $error("fill count out of range");

  // a blocked operand stage keeps its beat
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_ready) |=> s1_valid)
    else $error("operand beat dropped");

endmodule

`default_nettype wire
